@@ hdl/rtml_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtml_pkg: route table lookup types and codes
// shared request/response words, op codes and engine state
// ---------------------------------------------------------------------------
package rtml_pkg;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_LOOKUP = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_AGE    = 3'd4;

   localparam logic [15:0] METRIC_MAX = 16'hFFFF;
   localparam logic [7:0]  MAX_PRIORITY_RESET = 8'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] route_id;
      logic [15:0] dst_addr;
      logic [7:0]  priority_req;
      logic [7:0]  ttl;
      logic [15:0] first_hop;
      logic        hop_valid;
      logic [15:0] delta;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        found;
      logic [31:0] match_id;
      logic [15:0] match_metric;
      logic [15:0] fwd_hop;
   } rsp_type;

   // classified command from the front end
   typedef struct packed {
      req_type req;
      logic    prio_ok;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_DONE
   } eng_state_type;

endpackage

@@ hdl/route_table_min_metric_lookup_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// route_table_min_metric_lookup_top: route table with min-metric lookup
//
//   channel  ports                     direction
//   request  push full req_word        in
//   result   pop empty rsp_word        out
//   config   csr_we csr_wdata          in
//
// each word passes through the engine in order: the idle state picks it up,
// the scan reads one slot per cycle, the apply step updates the table and
// the done step posts the result.
// a two-entry queue lets req take words while the engine is busy.
// a held result stalls the apply step; the queue keeps taking words until full.
// synchronous reset empties the table and sets max priority to 3.
// ---------------------------------------------------------------------------
module route_table_min_metric_lookup_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  rtml_pkg::req_type req_word,
   output logic              empty,
   input  logic              pop,
   output rtml_pkg::rsp_type rsp_word,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);
   import rtml_pkg::*;

   cmd_type cmd_f, cmd_q;
   logic    q_empty, q_pop;

   rtml_front u_front (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_in(req_word), .cmd_out(cmd_f)
   );

   rtml_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(cmd_f),
      .full(full), .pop(q_pop), .empty(q_empty), .pop_data(cmd_q)
   );

   rtml_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock(clock), .reset(reset), .cmd_empty(q_empty), .cmd_in(cmd_q),
      .cmd_pop(q_pop), .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_word)
   );
endmodule

@@ hdl/rtml_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtml_front: request classifier
// checks the priority limit, holds the limit register
// ---------------------------------------------------------------------------
module rtml_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   input  rtml_pkg::req_type req_in,
   output rtml_pkg::cmd_type cmd_out
);
   import rtml_pkg::*;

   logic [7:0] max_prio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_prio_ff <= MAX_PRIORITY_RESET;
      end else if (csr_we) begin
         max_prio_ff <= csr_wdata;
      end
   end

   always_comb begin
      cmd_out.req      = req_in;
      cmd_out.prio_ok  = (req_in.priority_req <= max_prio_ff);
   end
endmodule

@@ hdl/rtml_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtml_queue: two-entry command queue
// decouples the classifier from the table engine
// ---------------------------------------------------------------------------
module rtml_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rtml_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output rtml_pkg::cmd_type pop_data
);
   import rtml_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wr_ff <= ~wr_ff;
         if (pop && !empty) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end
endmodule

@@ hdl/rtml_engine.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtml_engine: route table engine
// walks the slots one a cycle, then applies the command and posts a word
// ---------------------------------------------------------------------------
module rtml_engine #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  rtml_pkg::cmd_type cmd_in,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rtml_pkg::rsp_type rsp_data
);
   import rtml_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic        used_ff   [TABLE_DEPTH];
   logic        active_ff [TABLE_DEPTH];
   logic [31:0] id_ff     [TABLE_DEPTH];
   logic [15:0] dest_ff   [TABLE_DEPTH];
   logic [7:0]  ttl_ff    [TABLE_DEPTH];
   logic [15:0] metric_ff [TABLE_DEPTH];
   logic [15:0] hop_ff    [TABLE_DEPTH];

   eng_state_type state_ff, state_in;
   logic [CW-1:0] idx_ff;
   logic [IW-1:0] slot;
   logic          free_hit_ff, id_hit_ff, best_hit_ff;
   logic [IW-1:0] free_ff, id_slot_ff, best_ff;
   logic [15:0]   best_met_ff;
   logic [31:0]   best_id_ff;
   logic          rsp_full_ff;
   rsp_type       rsp_ff;
   req_type       rq;
   logic          last;

   assign rq        = cmd_in.req;
   assign slot      = idx_ff[IW-1:0];
   assign last      = (idx_ff == CW'(TABLE_DEPTH - 1));
   assign rsp_empty = !rsp_full_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      case (state_ff)
         ST_IDLE:  if (!cmd_empty) state_in = ST_SCAN;
         ST_SCAN:  if (last) state_in = ST_APPLY;
         // hold until the previous result word has been taken
         ST_APPLY: if (!rsp_full_ff) state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_full_ff) begin
               cmd_pop  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // scan: find free slot, id slot and best lookup candidate
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         free_hit_ff <= 1'b0;
         id_hit_ff <= 1'b0;
         best_hit_ff <= 1'b0;
      end else if (state_ff == ST_IDLE) begin
         idx_ff <= '0;
         free_hit_ff <= 1'b0;
         id_hit_ff <= 1'b0;
         best_hit_ff <= 1'b0;
         best_met_ff <= METRIC_MAX;
      end else if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + 1'b1;
         if (!used_ff[slot] && !free_hit_ff) begin
            free_hit_ff <= 1'b1;
            free_ff     <= slot;
         end
         if (used_ff[slot] && id_ff[slot] == rq.route_id && !id_hit_ff) begin
            id_hit_ff  <= 1'b1;
            id_slot_ff <= slot;
         end
         if (used_ff[slot] && active_ff[slot] && dest_ff[slot] == rq.dst_addr &&
             (metric_ff[slot] < best_met_ff ||
              (best_hit_ff && metric_ff[slot] == best_met_ff &&
               id_ff[slot] < best_id_ff))) begin
            best_hit_ff <= 1'b1;
            best_ff     <= slot;
            best_met_ff <= metric_ff[slot];
            best_id_ff  <= id_ff[slot];
         end
      end
   end

   // table update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_full_ff <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            used_ff[i]   <= 1'b0;
            active_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_pop && rsp_full_ff) rsp_full_ff <= 1'b0;
         if (state_ff == ST_APPLY && !rsp_full_ff) begin
            rsp_ff <= '0;
            case (rq.op)
               OP_ADD: begin
                  if (free_hit_ff && !id_hit_ff && cmd_in.prio_ok) begin
                     used_ff[free_ff]   <= 1'b1;
                     active_ff[free_ff] <= 1'b1;
                     id_ff[free_ff]     <= rq.route_id;
                     dest_ff[free_ff]   <= rq.dst_addr;
                     ttl_ff[free_ff]    <= rq.ttl;
                     metric_ff[free_ff] <= '0;
                     hop_ff[free_ff]    <= rq.hop_valid ? rq.first_hop : 16'd0;
                     rsp_ff.ok          <= 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (id_hit_ff) begin
                     used_ff[id_slot_ff]   <= 1'b0;
                     active_ff[id_slot_ff] <= 1'b0;
                     rsp_ff.ok             <= 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  if (best_hit_ff) begin
                     rsp_ff.found        <= 1'b1;
                     rsp_ff.match_id     <= id_ff[best_ff];
                     rsp_ff.match_metric <= metric_ff[best_ff];
                     rsp_ff.fwd_hop      <= hop_ff[best_ff];
                  end
               end
               OP_UPDATE: begin
                  if (id_hit_ff) begin
                     metric_ff[id_slot_ff] <= metric_ff[id_slot_ff] + rq.delta;
                     rsp_ff.ok             <= 1'b1;
                  end
               end
               OP_AGE: begin
                  // every lane counts down on its own
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (used_ff[i] && ttl_ff[i] != 8'd0) begin
                        ttl_ff[i] <= ttl_ff[i] - 8'd1;
                        if (ttl_ff[i] == 8'd1) active_ff[i] <= 1'b0;
                     end
                  end
                  rsp_ff.ok <= 1'b1;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && !rsp_full_ff) rsp_full_ff <= 1'b1;
      end
   end
endmodule

@@ verif/route_table_min_metric_lookup_top_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// route_table_min_metric_lookup_top_test: route table block test
// drives add, remove, lookup, update and age words against a table model,
// checks every result word in order under random idling and stalls
// ---------------------------------------------------------------------------
module route_table_min_metric_lookup_top_test;
   import rtml_pkg::*;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   req_type req_word = '0;
   logic full, empty;
   rsp_type rsp_word;

   route_table_min_metric_lookup_top #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_word(req_word), .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // table model
   logic [7:0]  mdl_max_prio;
   logic        mdl_used [DEPTH];
   logic        mdl_active [DEPTH];
   logic [31:0] mdl_id [DEPTH];
   logic [15:0] mdl_dest [DEPTH];
   logic [7:0]  mdl_ttl [DEPTH];
   logic [15:0] mdl_metric [DEPTH];
   logic [15:0] mdl_hop [DEPTH];

   rsp_type expected_rsps [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   logic [31:0] id_pool [8];

   function automatic int slot_with_id(logic [31:0] id);
      for (int i = 0; i < DEPTH; i++)
         if (mdl_used[i] && mdl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic rsp_type route_table_apply(req_type r);
      rsp_type o;
      int s;
      int best;
      logic [15:0] low_metric;
      o = '0;
      case (r.op)
         OP_ADD: begin
            s = -1;
            for (int i = DEPTH - 1; i >= 0; i--)
               if (!mdl_used[i]) s = i;
            if (s >= 0 && slot_with_id(r.route_id) < 0 && r.priority_req <= mdl_max_prio) begin
               mdl_used[s] = 1'b1;
               mdl_active[s] = 1'b1;
               mdl_id[s] = r.route_id;
               mdl_dest[s] = r.dst_addr;
               mdl_ttl[s] = r.ttl;
               mdl_metric[s] = '0;
               mdl_hop[s] = r.hop_valid ? r.first_hop : 16'd0;
               o.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            s = slot_with_id(r.route_id);
            if (s >= 0) begin
               mdl_used[s] = 1'b0;
               mdl_active[s] = 1'b0;
               o.ok = 1'b1;
            end
         end
         OP_LOOKUP: begin
            best = -1;
            low_metric = METRIC_MAX;
            for (int i = 0; i < DEPTH; i++) begin
               if (mdl_used[i] && mdl_active[i] && mdl_dest[i] == r.dst_addr &&
                   (mdl_metric[i] < low_metric || (best >= 0 &&
                    mdl_metric[i] == low_metric && mdl_id[i] < mdl_id[best]))) begin
                  best = i;
                  low_metric = mdl_metric[i];
               end
            end
            if (best >= 0) begin
               o.found = 1'b1;
               o.match_id = mdl_id[best];
               o.match_metric = mdl_metric[best];
               o.fwd_hop = mdl_hop[best];
            end
         end
         OP_UPDATE: begin
            s = slot_with_id(r.route_id);
            if (s >= 0) begin
               mdl_metric[s] = mdl_metric[s] + r.delta;
               o.ok = 1'b1;
            end
         end
         OP_AGE: begin
            for (int i = 0; i < DEPTH; i++)
               if (mdl_used[i] && mdl_ttl[i] != 8'd0) begin
                  mdl_ttl[i] = mdl_ttl[i] - 8'd1;
                  if (mdl_ttl[i] == 8'd0) mdl_active[i] = 1'b0;
               end
            o.ok = 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   // push stays high on return; callers that wait drop it first
   task automatic send_word(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_word <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_rsps.push_back(route_table_apply(r));
   endtask

   task automatic drain;
      push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_max_prio(logic [7:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      mdl_max_prio = v;
   endtask

   function automatic req_type mk(logic [2:0] op, logic [31:0] id, logic [15:0] dest,
                                  logic [7:0] prio, logic [7:0] ttl, logic [15:0] hop,
                                  logic hh, logic [15:0] delta);
      req_type r;
      r.op = op; r.route_id = id; r.dst_addr = dest; r.priority_req = prio;
      r.ttl = ttl; r.first_hop = hop; r.hop_valid = hh; r.delta = delta;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && pop && !empty) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_word);
            errors++;
         end else begin
            exp_w = expected_rsps.pop_front();
            if (rsp_word.ok !== exp_w.ok) begin
               $display("%0t: ok expected %h actual %h", $time, exp_w.ok, rsp_word.ok);
               errors++;
            end
            if (rsp_word.found !== exp_w.found) begin
               $display("%0t: found expected %h actual %h", $time, exp_w.found,
                        rsp_word.found);
               errors++;
            end
            if (rsp_word.match_id !== exp_w.match_id) begin
               $display("%0t: match_id expected %h actual %h", $time, exp_w.match_id,
                        rsp_word.match_id);
               errors++;
            end
            if (rsp_word.match_metric !== exp_w.match_metric) begin
               $display("%0t: match_metric expected %h actual %h", $time,
                        exp_w.match_metric, rsp_word.match_metric);
               errors++;
            end
            if (rsp_word.fwd_hop !== exp_w.fwd_hop) begin
               $display("%0t: fwd_hop expected %h actual %h", $time, exp_w.fwd_hop,
                        rsp_word.fwd_hop);
               errors++;
            end
         end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic test_directed;
      write_max_prio(8'd3);
      send_word(mk(OP_LOOKUP, '0, 16'h0000, '0, '0, '0, '0, '0));
      send_word(mk(OP_ADD, 32'h0, 16'h0000, 8'd0, 8'd0, 16'hFFFF, 1'b1, '0));
      send_word(mk(OP_ADD, 32'hFFFFFFFF, 16'h0000, 8'd3, 8'd2, 16'h1234, 1'b0, '0));
      send_word(mk(OP_ADD, 32'h5, 16'h0000, 8'd4, 8'd0, 16'h1, 1'b1, '0));
      send_word(mk(OP_ADD, 32'h0, 16'hFFFF, 8'd0, 8'd0, 16'h1, 1'b1, '0));
      send_word(mk(OP_LOOKUP, '0, 16'h0000, '0, '0, '0, '0, '0));
      send_word(mk(OP_UPDATE, 32'h0, '0, '0, '0, '0, '0, 16'hFFFF));
      send_word(mk(OP_LOOKUP, '0, 16'h0000, '0, '0, '0, '0, '0));
      send_word(mk(OP_AGE, '0, '0, '0, '0, '0, '0, '0));
      send_word(mk(OP_AGE, '0, '0, '0, '0, '0, '0, '0));
      send_word(mk(OP_LOOKUP, '0, 16'h0000, '0, '0, '0, '0, '0));
      send_word(mk(OP_UPDATE, 32'hFFFFFFFF, '0, '0, '0, '0, '0, 16'h0001));
      send_word(mk(OP_UPDATE, 32'h77, '0, '0, '0, '0, '0, 16'h0001));
      send_word(mk(OP_REMOVE, 32'hFFFFFFFF, '0, '0, '0, '0, '0, '0));
      send_word(mk(OP_REMOVE, 32'hFFFFFFFF, '0, '0, '0, '0, '0, '0));
      send_word(mk(3'd5, 32'h1, 16'h1, 8'h1, 8'h1, 16'h1, 1'b1, 16'h1));
      send_word(mk(3'd7, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF));
      // fill the table to hit the full case
      for (int i = 0; i < DEPTH + 1; i++)
         send_word(mk(OP_ADD, 32'h100 + i, 16'h00AA, 8'd0, 8'hFF, i[15:0], 1'b1, '0));
      send_word(mk(OP_LOOKUP, '0, 16'h00AA, '0, '0, '0, '0, '0));
      write_max_prio(8'd255);
      send_word(mk(OP_ADD, 32'h999, 16'h1, 8'd255, '0, '0, '0, '0));
      for (int i = 0; i < DEPTH + 1; i++)
         send_word(mk(OP_REMOVE, 32'h100 + i, '0, '0, '0, '0, '0, '0));
      send_word(mk(OP_REMOVE, 32'h0, '0, '0, '0, '0, '0, '0));
      write_max_prio(8'd0);
      send_word(mk(OP_ADD, 32'h999, 16'h1, 8'd1, '0, '0, '0, '0));
   endtask

   task automatic test_random(int count);
      req_type r;
      int pick;
      logic [127:0] raw;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         raw = {$urandom, $urandom, $urandom, $urandom};
         r = raw[$bits(req_type)-1:0];
         r.route_id = id_pool[$urandom_range(7)];
         r.dst_addr = {14'd0, r.dst_addr[1:0]};
         r.priority_req = (pick < 90) ? mdl_max_prio : r.priority_req;
         r.ttl = ($urandom_range(3) == 0) ? 8'd0 : {4'd0, r.ttl[3:0]};
         r.delta = ($urandom_range(3) == 0) ? 16'hFFFF - {12'd0, r.delta[3:0]}
                                            : {12'd0, r.delta[3:0]};
         if (pick < 30) r.op = OP_ADD;
         else if (pick < 45) r.op = OP_REMOVE;
         else if (pick < 70) r.op = OP_LOOKUP;
         else if (pick < 85) r.op = OP_UPDATE;
         else if (pick < 95) r.op = OP_AGE;
         if (pick == 99) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            r = raw[$bits(req_type)-1:0];
         end
         send_word(r);
         // one long hold-off until the table catches up
         if (n == count / 2) begin
            push <= 1'b0;
            while (expected_rsps.size() != 0) @(posedge clock);
         end
      end
   endtask

   task automatic new_id_pool;
      for (int i = 0; i < 8; i++) id_pool[i] = ($urandom_range(1)) ? $urandom : i;
   endtask

   initial begin
      mdl_max_prio = MAX_PRIORITY_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         mdl_used[i] = 1'b0; mdl_active[i] = 1'b0; mdl_id[i] = '0; mdl_dest[i] = '0;
         mdl_ttl[i] = '0; mdl_metric[i] = '0; mdl_hop[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_max_prio(8'd3);
      new_id_pool();
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(300);
      write_max_prio(8'd255);
      new_id_pool();
      send_idle_pct = 81; recv_stall_pct = 0;
      test_random(300);
      write_max_prio(8'd0);
      new_id_pool();
      send_idle_pct = 0; recv_stall_pct = 81;
      test_random(300);
      write_max_prio(8'($urandom_range(255)));
      new_id_pool();
      send_idle_pct = 25; recv_stall_pct = 25;
      test_random(300);
      recv_stall_pct = 0;
      drain();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
